// ===== hw/rtl/bspline_basis_uniform_knots_macros.svh =====
// ----------------------------------------------------------------------------
// B-spline basis evaluator assertion macros
// Shorthand for clocked checks on the evaluator's own logic.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_BASIS_UNIFORM_KNOTS_MACROS_SVH
`define BSPLINE_BASIS_UNIFORM_KNOTS_MACROS_SVH

// Check a same-cycle implication.
`define BSBU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the following cycle.
`define BSBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bsbu_pkg.sv =====
// ----------------------------------------------------------------------------
// B-spline basis evaluator package
// Limits, register codes and pipeline payload types.
// ----------------------------------------------------------------------------
package bsbu_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int MAX_ORDER     = 3;
    localparam int GRID_CAP      = MAX_INTERVALS - 2 * MAX_ORDER;

    // Configuration register codes
    typedef enum logic [1:0] {
        REG_INTERVALS = 2'd0,
        REG_DEGREE    = 2'd1
    } cfg_reg_t;

    // Recursion stages: interval, fraction and the basis terms per order
    typedef struct packed {
        logic                         neg;
        logic [4:0]                   j;
        logic [13:0]                  t;
        logic                         a0;
        logic [1:0][13:0]             a1;
        logic [2:0][27:0]             a2;
        logic [MAX_ORDER:0][42:0]     a3;
    } knot_t;

    // Normalization stage
    typedef struct packed {
        logic [4:0]                   j;
        logic [MAX_ORDER:0][16:0]     vs;
        logic [MAX_ORDER:0][16:0]     y;
        logic [MAX_ORDER:0][23:0]     s;
    } norm_t;

    // Final per-sample results, indexed by offset from the interval
    typedef struct packed {
        logic [4:0]                   j;
        logic [MAX_ORDER:0][15:0]     v;
        logic [MAX_ORDER:0][23:0]     s;
    } res_t;

endpackage

// ===== hw/rtl/bspline_basis_uniform_knots.sv =====
// ----------------------------------------------------------------------------
// Uniform-knot B-spline basis evaluator
// Cox-de Boor recursion in the knot coordinate, pipelined, serial results.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    x_value
// out      output     out_valid / out_ready  basis_index, basis_value,
//                                            basis_slope, last
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample passes seven register stages, then the output register emits
// one result per basis function (interval count plus degree, 29 at most),
// one per cycle while out_ready is high; the output port sets the rate.
// Samples keep entering while earlier results drain; a stall on out_ready
// backs up the stages one by one without losing data.
// Reset (rst_n low) empties all stages and loads 5 intervals, degree 3.
// ----------------------------------------------------------------------------
`include "bspline_basis_uniform_knots_macros.svh"

module bspline_basis_uniform_knots
    import bsbu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         basis_index,
    output logic [15:0]        basis_value,
    output logic signed [23:0] basis_slope,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data
);

    logic [4:0]         intervals_reg;
    logic [1:0]         degree_reg;
    logic [4:0]         g;
    logic [1:0]         k;
    logic [5:0]         n0;
    logic [4:0]         nb;

    logic [7:1]         vld_reg;
    logic [7:1]         vld_next;
    logic [8:1]         adv;

    logic signed [16:0] xs;
    logic signed [22:0] u_next;
    logic signed [22:0] u_reg;
    knot_t              st2_next, st2_reg;
    knot_t              st3_next, st3_reg;
    knot_t              st4_next, st4_reg;
    knot_t              st5_next, st5_reg;
    norm_t              st6_next, st6_reg;
    res_t               st7_next, st7_reg;

    res_t               emit_reg;
    logic [4:0]         idx_reg;
    logic               busy_reg;
    logic [5:0]         offs;
    logic [1:0]         m_sel;
    logic               in_win;
    logic               last_w;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intervals_reg <= 5'd5;
            degree_reg    <= 2'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INTERVALS: intervals_reg <= cfg_data;
                REG_DEGREE:    degree_reg    <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    // Effective grid and order
    always_comb
    begin
        if (intervals_reg == 5'd0)
            g = 5'd1;
        else if (intervals_reg > 5'(GRID_CAP))
            g = 5'(GRID_CAP);
        else
            g = intervals_reg;
        k  = degree_reg;
        n0 = {1'b0, g} + {3'b0, k, 1'b0};
        nb = g + {3'b0, k};
    end

    // Stage flow control: adv[n] loads stage n, adv[8] loads the output
    always_comb
    begin
        adv[8] = vld_reg[7] && (!busy_reg || (out_ready && last_w));
        for (int n = 7; n >= 2; n--)
            adv[n] = vld_reg[n-1] && (!vld_reg[n] || adv[n+1]);
        adv[1]   = in_valid && (!vld_reg[1] || adv[2]);
        in_ready = !vld_reg[1] || adv[2];
        for (int n = 1; n <= 7; n++)
            vld_next[n] = adv[n] ? 1'b1 : (adv[n+1] ? 1'b0 : vld_reg[n]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 1: knot coordinate u = (x+1)*g/2 + k in 1/8192 units
    always_comb
    begin
        xs     = $signed({x_value[15], x_value}) + 17'sd4096;
        u_next = 23'(xs * $signed({1'b0, g})) + $signed({8'b0, k, 13'b0});
    end

    // Stage 2: interval and fraction, saturate at the last knot
    always_comb
    begin
        logic clamp;
        st2_next     = '0;
        st2_next.neg = u_reg[22];
        clamp        = !u_reg[22] && (u_reg[21:0] >= {3'b0, n0, 13'b0});
        if (clamp)
        begin
            st2_next.j = 5'(n0 - 6'd1);
            st2_next.t = 14'd8192;
        end
        else
        begin
            st2_next.j = u_reg[17:13];
            st2_next.t = {1'b0, u_reg[12:0]};
        end
    end

    // Stage 3: order 1 terms
    always_comb
    begin
        st3_next    = st2_reg;
        st3_next.a0 = !st2_reg.neg;
        for (int m = 0; m < 2; m++)
        begin
            if (st3_next.a0)
                st3_next.a1[m] = (m == 0) ? st2_reg.t : 14'(14'd8192 - st2_reg.t);
            else
                st3_next.a1[m] = '0;
            // drop terms past the top of the truncated table
            if (({2'b0, st2_reg.j} + 7'd1) >= ({1'b0, n0} + 7'(m)))
                st3_next.a1[m] = '0;
        end
    end

    // Stage 4: order 2 terms
    always_comb
    begin
        logic [15:0] c0, c1;
        logic [29:0] acc;
        st4_next = st3_reg;
        for (int m = 0; m < 3; m++)
        begin
            c0  = 16'(8192 * m) + {2'b0, st3_reg.t};
            c1  = 16'(8192 * (3 - m)) - {2'b0, st3_reg.t};
            acc = '0;
            if (m <= 1)
                acc = acc + 30'(c0 * st3_reg.a1[(m <= 1) ? m : 1]);
            if (m >= 1)
                acc = acc + 30'(c1 * st3_reg.a1[(m >= 1) ? m - 1 : 0]);
            if (({2'b0, st3_reg.j} + 7'd2) >= ({1'b0, n0} + 7'(m)))
                acc = '0;
            st4_next.a2[m] = acc[27:0];
        end
    end

    // Stage 5: order 3 terms
    always_comb
    begin
        logic [15:0] c0, c1;
        logic [43:0] acc;
        st5_next = st4_reg;
        for (int m = 0; m < 4; m++)
        begin
            c0  = 16'(8192 * m) + {2'b0, st4_reg.t};
            c1  = 16'(8192 * (4 - m)) - {2'b0, st4_reg.t};
            acc = '0;
            if (m <= 2)
                acc = acc + 44'(c0 * st4_reg.a2[(m <= 2) ? m : 2]);
            if (m >= 1)
                acc = acc + 44'(c1 * st4_reg.a2[(m >= 1) ? m - 1 : 0]);
            if (({2'b0, st4_reg.j} + 7'd3) >= ({1'b0, n0} + 7'(m)))
                acc = '0;
            st5_next.a3[m] = acc[42:0];
        end
    end

    // Stage 6: scale values, form slopes from the order k-1 differences
    always_comb
    begin
        logic [28:0]        pv [0:4];
        logic signed [29:0] d;
        logic signed [35:0] p;
        logic [35:0]        mag;
        logic [35:0]        r;
        st6_next   = '0;
        st6_next.j = st5_reg.j;
        for (int m = 0; m <= 4; m++)
            pv[m] = '0;
        case (k)
            2'd1: pv[0] = {28'b0, st5_reg.a0};
            2'd2:
            begin
                pv[0] = {15'b0, st5_reg.a1[0]};
                pv[1] = {15'b0, st5_reg.a1[1]};
            end
            2'd3:
            begin
                pv[0] = {1'b0, st5_reg.a2[0]};
                pv[1] = {1'b0, st5_reg.a2[1]};
                pv[2] = {1'b0, st5_reg.a2[2]};
            end
            default: ;
        endcase
        for (int m = 0; m < 4; m++)
        begin
            // value for orders 0 to 2, prescaled sum for order 3
            case (k)
                2'd0: st6_next.vs[m] = (m == 0 && st5_reg.a0) ? 17'd32768 : 17'd0;
                2'd1: st6_next.vs[m] = (m <= 1) ? 17'({st5_reg.a1[m % 2], 2'b0}) : 17'd0;
                2'd2: st6_next.vs[m] = (m <= 2) ?
                          17'((29'(st5_reg.a2[m % 3]) + 29'd2048) >> 12) : 17'd0;
                default: st6_next.vs[m] = '0;
            endcase
            st6_next.y[m] = 17'((44'(st5_reg.a3[m]) + 44'd50331648) >> 25);
            d   = $signed({1'b0, pv[m]}) -
                  ((m == 0) ? 30'sd0 : $signed({1'b0, pv[(m == 0) ? 0 : m - 1]}));
            p   = 36'(d * $signed({1'b0, g}));
            mag = p[35] ? 36'(-p) : p;
            r   = (mag + 36'd4096) >> 13;
            case (k)
                2'd1:    st6_next.s[m] = 24'(p <<< 14);
                2'd2:    st6_next.s[m] = 24'(p <<< 1);
                2'd3:    st6_next.s[m] = p[35] ? 24'(-r) : 24'(r);
                default: st6_next.s[m] = '0;
            endcase
        end
    end

    // Stage 7: divide the order 3 sum by 3 and clip at one; other orders pass the values
    always_comb
    begin
        logic [33:0] q;
        st7_next.j = st6_reg.j;
        st7_next.s = st6_reg.s;
        for (int m = 0; m < 4; m++)
        begin
            q = (34'(st6_reg.y[m]) * 34'd43691) >> 17;
            if (k == 2'd3)
                st7_next.v[m] = (q > 34'd32768) ? 16'd32768 : q[15:0];
            else
                st7_next.v[m] = st6_reg.vs[m][15:0];
        end
    end

    // Stage payload registers, each held while its stage stalls
    always_ff @(posedge clk)
    begin
        if (adv[1]) u_reg   <= u_next;
        if (adv[2]) st2_reg <= st2_next;
        if (adv[3]) st3_reg <= st3_next;
        if (adv[4]) st4_reg <= st4_next;
        if (adv[5]) st5_reg <= st5_next;
        if (adv[6]) st6_reg <= st6_next;
        if (adv[7]) st7_reg <= st7_next;
        if (adv[8]) emit_reg <= st7_reg;
    end

    // Output sequencer: walk the basis indices, one per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (adv[8])
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (last_w)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 5'd1;
        end
    end

    // Pick the nonzero window around the sample's interval
    always_comb
    begin
        offs   = {1'b0, emit_reg.j} - {1'b0, idx_reg};
        in_win = !offs[5] && (offs[4:2] == 3'd0);
        m_sel  = offs[1:0];
        last_w = (idx_reg == nb - 5'd1);
    end

    assign out_valid   = busy_reg;
    assign basis_index = idx_reg;
    assign basis_value = in_win ? emit_reg.v[m_sel] : 16'd0;
    assign basis_slope = in_win ? $signed(emit_reg.s[m_sel]) : 24'sd0;
    assign last        = last_w;

    // Checks
    `BSBU_ASSERT_NOW(a_value_max, out_valid, basis_value <= 16'd32768, "basis value above one")
    `BSBU_ASSERT_NOW(a_idx_range, out_valid, basis_index < nb, "basis index past the last")
    `BSBU_ASSERT_NEXT(a_idx_step, out_valid && out_ready && !last, out_valid && basis_index == $past(basis_index) + 5'd1, "basis index skipped")
    `BSBU_ASSERT_NOW(a_full_stall, !in_ready, vld_reg[1] && vld_reg[2], "input stalled with room")

endmodule
